FILE: hw/rtl/tdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdr_pkg;

  // Longest delimiter that a change may install.
  localparam int unsigned MaxDelim = 8;
  // Default depth of the lookahead window, in bytes.
  localparam int unsigned DefWindowDepth = 20;
  // Entries in the command queue between the front and back parts.
  localparam int unsigned FifoDepth = 4;
  // Bytes in the fixed head of the set-delimiters tag.
  localparam int unsigned HeadLen = 23;

  // Configuration register indexes.
  localparam logic [2:0] CFG_OPEN_BYTES  = 3'd0;
  localparam logic [2:0] CFG_OPEN_LEN    = 3'd1;
  localparam logic [2:0] CFG_CLOSE_BYTES = 3'd2;
  localparam logic [2:0] CFG_CLOSE_LEN   = 3'd3;
  localparam logic [2:0] CFG_BRACE       = 3'd4;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_NO_SPACE = 3'd1;
  localparam logic [2:0] ERR_NO_EQ    = 3'd2;
  localparam logic [2:0] ERR_NO_CLOSE = 3'd3;
  localparam logic [2:0] ERR_LONG     = 3'd4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_PAIR,
    CMD_ERR,
    CMD_COMMIT
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic [2:0] error_code;
  } out_item_t;

  typedef struct packed {
    logic [63:0] open_bytes;
    logic [3:0]  open_len;
    logic [63:0] close_bytes;
    logic [3:0]  close_len;
    logic        brace;
  } cfg_t;

  // One unit of work for the back part.
  typedef struct packed {
    cmd_kind_e   kind;
    logic        last;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [2:0]  err;
    logic [63:0] open_bytes;
    logic [63:0] close_bytes;
    logic [3:0]  open_len;
    logic [3:0]  close_len;
  } cmd_t;

  // Register length as used: zero reads as one, long values clip.
  function automatic logic [3:0] eff_len(logic [3:0] len);
    logic [3:0] r;
    r = len;
    if (len == 4'd0) r = 4'd1;
    else if (len > 4'(MaxDelim)) r = 4'(MaxDelim);
    return r;
  endfunction

  // Fixed head of the set-delimiters tag, ending in an opening quote.
  function automatic logic [7:0] head_byte(logic [4:0] i);
    logic [7:0] r;
    unique case (i)
      5'd0:  r = 8'h7B;
      5'd1:  r = 8'h7B;
      5'd2:  r = 8'h68;
      5'd3:  r = 8'h62;
      5'd4:  r = 8'h73;
      5'd5:  r = 8'h63;
      5'd6:  r = 8'h5F;
      5'd7:  r = 8'h73;
      5'd8:  r = 8'h65;
      5'd9:  r = 8'h74;
      5'd10: r = 8'h5F;
      5'd11: r = 8'h64;
      5'd12: r = 8'h65;
      5'd13: r = 8'h6C;
      5'd14: r = 8'h69;
      5'd15: r = 8'h6D;
      5'd16: r = 8'h69;
      5'd17: r = 8'h74;
      5'd18: r = 8'h65;
      5'd19: r = 8'h72;
      5'd20: r = 8'h73;
      5'd21: r = 8'h20;
      5'd22: r = 8'h22;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tdr_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tdr_cmd_fifo #(
  parameter int unsigned DEPTH = tdr_pkg::FifoDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tdr_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output tdr_pkg::cmd_t      pop_data_o,
  output logic               empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tdr_pkg::cmd_t  mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tdr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tdr_front #(
  parameter int unsigned WINDOW_DEPTH = tdr_pkg::DefWindowDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tdr_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tdr_pkg::in_item_t in_data_i,
  output logic                   push_valid_o,
  output tdr_pkg::cmd_t          push_data_o,
  input  wire logic              fifo_full_i
);

  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned IW = $clog2(WINDOW_DEPTH);
  localparam int unsigned XN = WINDOW_DEPTH + 9;
  localparam int unsigned XW = $clog2(XN);
  localparam int unsigned NW = 7;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RUN  = 2'd1;
  localparam logic [1:0] F_END  = 2'd2;

  localparam logic [2:0] M_TEXT  = 3'd0;
  localparam logic [2:0] M_TAG   = 3'd1;
  localparam logic [2:0] M_LEAD  = 3'd2;
  localparam logic [2:0] M_OPEN  = 3'd3;
  localparam logic [2:0] M_MID   = 3'd4;
  localparam logic [2:0] M_CLOSE = 3'd5;
  localparam logic [2:0] M_MATCH = 3'd6;
  localparam logic [2:0] M_SINK  = 3'd7;

  logic [1:0]    st_q, st_d;
  logic          in_tpl_q, in_tpl_d;
  logic          flush_q, flush_d;
  logic [2:0]    mode_q, mode_d;
  logic [63:0]   open_q, open_d, close_q, close_d;
  logic [3:0]    olen_q, olen_d, clen_q, clen_d;
  logic          brace_q, brace_d;
  logic [7:0]    win_q [WINDOW_DEPTH];
  logic [7:0]    win_d [WINDOW_DEPTH];
  logic [CW-1:0] cnt_q, cnt_d;
  logic [63:0]   popen_q, popen_d, pclose_q, pclose_d;
  logic [3:0]    pol_q, pol_d, pcl_q, pcl_d;
  logic [3:0]    aux_q, aux_d;
  logic          skip_q, skip_d;
  logic          pend_v_q, pend_v_d;
  tdr_pkg::cmd_t pend_q, pend_d;

  logic [7:0]    win_x [XN];
  logic          mo, mc;
  logic [NW-1:0] cnt7, nd, oc;
  logic          act_cond, blocked;
  logic [7:0]    b, bo;
  logic          new_v;
  tdr_pkg::cmd_t new_cmd;
  logic [3:0]    pk;
  logic          do_pop, pop_all;
  logic [CW-1:0] base_cnt;
  logic [4:0]    csum;

  // Window padded with zeros so fixed taps past the end read safely.
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) win_x[i] = win_q[i];
    for (int i = WINDOW_DEPTH; i < XN; i++) win_x[i] = 8'h00;
  end

  // Delimiter matches at the head of the window.
  always_comb begin
    mo = 1'b1;
    mc = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < olen_q && (NW'(k) >= cnt7 || win_x[k] != open_q[8*k +: 8])) mo = 1'b0;
      if (4'(k) < clen_q && (NW'(k) >= cnt7 || win_x[k] != close_q[8*k +: 8])) mc = 1'b0;
    end
  end

  // Bytes the current mode wants in the window before it decides.
  always_comb begin
    cnt7 = NW'(cnt_q);
    oc   = NW'(olen_q) + NW'(clen_q);
    if (mode_q == M_TEXT) nd = skip_q ? NW'(1) : oc + NW'(4);
    else if (mode_q == M_TAG) nd = NW'(clen_q);
    else nd = NW'(1);
    if (nd > NW'(WINDOW_DEPTH)) nd = NW'(WINDOW_DEPTH);
    act_cond = (cnt_q != '0) && (flush_q || cnt7 >= nd);
    blocked  = pend_v_q && fifo_full_i;
    b        = win_x[0];
    bo       = win_x[XW'(olen_q)];
  end

  always_comb begin
    st_d     = st_q;
    in_tpl_d = in_tpl_q;
    flush_d  = flush_q;
    mode_d   = mode_q;
    open_d   = open_q;
    close_d  = close_q;
    olen_d   = olen_q;
    clen_d   = clen_q;
    brace_d  = brace_q;
    win_d    = win_q;
    cnt_d    = cnt_q;
    popen_d  = popen_q;
    pclose_d = pclose_q;
    pol_d    = pol_q;
    pcl_d    = pcl_q;
    aux_d    = aux_q;
    skip_d   = skip_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    new_v    = 1'b0;
    new_cmd  = '0;
    pk       = 4'd1;
    do_pop   = 1'b0;
    pop_all  = 1'b0;
    base_cnt = '0;
    csum     = 5'(pcl_q) + 5'(aux_q);
    push_valid_o = 1'b0;
    push_data_o  = pend_q;

    unique case (st_q)
      F_IDLE: begin
        // Accept a byte; the first one of a template loads the registers.
        if (in_valid_i) begin
          base_cnt = cnt_q;
          if (!in_tpl_q) begin
            in_tpl_d = 1'b1;
            mode_d   = M_TEXT;
            open_d   = cfg_i.open_bytes;
            olen_d   = tdr_pkg::eff_len(cfg_i.open_len);
            close_d  = cfg_i.close_bytes;
            clen_d   = tdr_pkg::eff_len(cfg_i.close_len);
            brace_d  = cfg_i.brace;
            popen_d  = '0;
            pclose_d = '0;
            pol_d    = '0;
            pcl_d    = '0;
            aux_d    = '0;
            skip_d   = 1'b0;
            base_cnt = '0;
          end
          if (base_cnt < CW'(WINDOW_DEPTH)) begin
            win_d[base_cnt[IW-1:0]] = in_data_i.in_byte;
            cnt_d = base_cnt + CW'(1);
          end else begin
            cnt_d = base_cnt;
          end
          flush_d = in_data_i.in_last;
          st_d    = F_RUN;
        end
      end

      F_RUN: begin
        if (act_cond && !blocked) begin
          // One decision on the head of the window.
          unique case (mode_q)
            M_TEXT: begin
              do_pop = 1'b1;
              if (skip_q) begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_BYTE; new_cmd.b0 = b;
                skip_d = 1'b0;
              end else if (b == tdr_pkg::CH_BSLASH) begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_BYTE; new_cmd.b0 = b;
                skip_d = 1'b1;
              end else if ((!flush_q || cnt7 >= oc + NW'(4)) && mo &&
                           NW'(olen_q) < cnt7 && bo == tdr_pkg::CH_EQ) begin
                pk       = olen_q + 4'd1;
                popen_d  = '0;
                pclose_d = '0;
                pol_d    = '0;
                pcl_d    = '0;
                aux_d    = '0;
                mode_d   = M_LEAD;
              end else if ((!flush_q || cnt7 >= oc + NW'(1)) && mo) begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_PAIR;
                new_cmd.b0 = tdr_pkg::CH_LBRACE; new_cmd.b1 = tdr_pkg::CH_LBRACE;
                pk     = olen_q;
                mode_d = M_TAG;
              end else if (cnt7 >= NW'(2) && b == tdr_pkg::CH_LBRACE &&
                           win_x[1] == tdr_pkg::CH_LBRACE && !brace_q) begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_PAIR;
                new_cmd.b0 = tdr_pkg::CH_BSLASH; new_cmd.b1 = b;
              end else begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_BYTE; new_cmd.b0 = b;
              end
            end
            M_TAG: begin
              do_pop = 1'b1;
              if ((!flush_q || cnt7 >= NW'(clen_q)) && mc) begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_PAIR;
                new_cmd.b0 = tdr_pkg::CH_RBRACE; new_cmd.b1 = tdr_pkg::CH_RBRACE;
                pk     = clen_q;
                mode_d = M_TEXT;
              end else begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_BYTE; new_cmd.b0 = b;
              end
            end
            M_LEAD: begin
              do_pop = 1'b1;
              if (b != tdr_pkg::CH_SPACE) begin
                popen_d = {56'h0, b};
                pol_d   = 4'd1;
                pcl_d   = 4'd0;
                mode_d  = M_OPEN;
              end
            end
            M_OPEN: begin
              do_pop = 1'b1;
              if (b == tdr_pkg::CH_SPACE) begin
                mode_d = M_MID;
              end else if (pol_q >= 4'(tdr_pkg::MaxDelim)) begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_ERR; new_cmd.err = tdr_pkg::ERR_LONG;
                mode_d = M_SINK;
              end else begin
                popen_d[8*pol_q[2:0] +: 8] = b;
                pol_d = pol_q + 4'd1;
              end
            end
            M_MID: begin
              do_pop = 1'b1;
              if (b == tdr_pkg::CH_EQ) begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_ERR; new_cmd.err = tdr_pkg::ERR_LONG;
                mode_d = M_SINK;
              end else if (b != tdr_pkg::CH_SPACE) begin
                pclose_d = {56'h0, b};
                pcl_d    = 4'd1;
                aux_d    = '0;
                mode_d   = M_CLOSE;
              end
            end
            M_CLOSE: begin
              do_pop = 1'b1;
              if (b == tdr_pkg::CH_EQ) begin
                aux_d  = '0;
                mode_d = M_MATCH;
              end else if (b == tdr_pkg::CH_SPACE) begin
                if (aux_q < 4'd15) aux_d = aux_q + 4'd1;
              end else if (csum + 5'd1 > 5'(tdr_pkg::MaxDelim)) begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_ERR; new_cmd.err = tdr_pkg::ERR_LONG;
                mode_d = M_SINK;
              end else begin
                // Inner spaces held back so far go in ahead of this byte.
                for (int j = 0; j < 8; j++) begin
                  if (4'(j) >= pcl_q && 5'(j) < csum) pclose_d[8*j +: 8] = tdr_pkg::CH_SPACE;
                  else if (5'(j) == csum) pclose_d[8*j +: 8] = b;
                end
                pcl_d = 4'(csum + 5'd1);
                aux_d = '0;
              end
            end
            M_MATCH: begin
              do_pop = 1'b1;
              if (b != close_q[8*aux_q[2:0] +: 8]) begin
                new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_ERR;
                new_cmd.err = tdr_pkg::ERR_NO_CLOSE;
                mode_d = M_SINK;
              end else begin
                aux_d = aux_q + 4'd1;
                if (aux_q + 4'd1 >= clen_q) begin
                  // Install the new delimiters and announce them.
                  open_d  = popen_q;
                  olen_d  = pol_q;
                  close_d = pclose_q;
                  clen_d  = pcl_q;
                  brace_d = (popen_q[7:0] == tdr_pkg::CH_LBRACE);
                  new_v = 1'b1;
                  new_cmd.kind        = tdr_pkg::CMD_COMMIT;
                  new_cmd.open_bytes  = popen_q;
                  new_cmd.close_bytes = pclose_q;
                  new_cmd.open_len    = pol_q;
                  new_cmd.close_len   = pcl_q;
                  mode_d = M_TEXT;
                end
              end
            end
            default: begin
              do_pop  = 1'b1;
              pop_all = 1'b1;
            end
          endcase
        end else if (!act_cond && !blocked) begin
          // End of the step: an unfinished change at template end is an error.
          if (flush_q) begin
            if (mode_q == M_LEAD || mode_q == M_OPEN) begin
              new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_ERR; new_cmd.err = tdr_pkg::ERR_NO_SPACE;
            end else if (mode_q == M_MID || mode_q == M_CLOSE) begin
              new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_ERR; new_cmd.err = tdr_pkg::ERR_NO_EQ;
            end else if (mode_q == M_MATCH) begin
              new_v = 1'b1; new_cmd.kind = tdr_pkg::CMD_ERR;
              new_cmd.err = tdr_pkg::ERR_NO_CLOSE;
            end
            in_tpl_d = 1'b0;
            cnt_d    = '0;
            mode_d   = M_TEXT;
          end
          st_d = F_END;
        end
      end

      F_END: begin
        // The held command is the last result of this step.
        if (pend_v_q) begin
          if (!fifo_full_i) begin
            push_valid_o     = 1'b1;
            push_data_o.last = 1'b1;
            pend_v_d         = 1'b0;
            st_d             = F_IDLE;
          end
        end else begin
          st_d = F_IDLE;
        end
      end

      default: st_d = F_IDLE;
    endcase

    // Drop consumed bytes from the head of the window.
    if (do_pop) begin
      if (pop_all || cnt7 < NW'(pk)) cnt_d = '0;
      else cnt_d = CW'(cnt7 - NW'(pk));
      for (int i = 0; i < WINDOW_DEPTH; i++) win_d[i] = win_x[XW'(i) + XW'(pk)];
    end

    // One command is held back until the next one shows whether it was last.
    if (new_v) begin
      if (pend_v_q) push_valid_o = 1'b1;
      pend_d   = new_cmd;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= F_IDLE;
      in_tpl_q <= 1'b0;
      flush_q  <= 1'b0;
      mode_q   <= M_TEXT;
      cnt_q    <= '0;
      skip_q   <= 1'b0;
      pend_v_q <= 1'b0;
      aux_q    <= '0;
    end else begin
      st_q     <= st_d;
      in_tpl_q <= in_tpl_d;
      flush_q  <= flush_d;
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      skip_q   <= skip_d;
      pend_v_q <= pend_v_d;
      aux_q    <= aux_d;
    end
  end

  // Delimiters, window bytes and the pending command.
  always_ff @(posedge clk_i) begin
    open_q   <= open_d;
    close_q  <= close_d;
    olen_q   <= olen_d;
    clen_q   <= clen_d;
    brace_q  <= brace_d;
    win_q    <= win_d;
    popen_q  <= popen_d;
    pclose_q <= pclose_d;
    pol_q    <= pol_d;
    pcl_q    <= pcl_d;
    pend_q   <= pend_d;
  end

  assign in_ready_o = (st_q == F_IDLE);

  // The window never holds more bytes than it has room for.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(WINDOW_DEPTH))
    else $error("lookahead count beyond window depth");

  // A step never ends with a command still held back.
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == F_IDLE) |-> !pend_v_q)
    else $error("held command left at end of step");

  // Commands go into the queue only when it has room.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> !fifo_full_i)
    else $error("push into a full command queue");

endmodule

`default_nettype wire

FILE: hw/rtl/tdr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tdr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  output logic               pop_o,
  input  wire tdr_pkg::cmd_t pop_data_i,
  input  wire logic          empty_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tdr_pkg::out_item_t out_data_o
);

  localparam logic [2:0] P_HEAD  = 3'd0;
  localparam logic [2:0] P_OPEN  = 3'd1;
  localparam logic [2:0] P_MID   = 3'd2;
  localparam logic [2:0] P_CLOSE = 3'd3;
  localparam logic [2:0] P_TAIL  = 3'd4;

  logic               busy_q, busy_d;
  tdr_pkg::cmd_t      cmd_q, cmd_d;
  logic [2:0]         ph_q, ph_d;
  logic [4:0]         idx_q, idx_d;
  logic               esc_q, esc_d;
  logic               oval_q, oval_d;
  tdr_pkg::out_item_t out_q, out_d;

  logic               slot_free, done;
  logic [7:0]         ob, db;
  logic [3:0]         dlen;

  assign slot_free = !oval_q || out_ready_i;
  assign pop_o     = !busy_q && !empty_i;

  // Next output byte of the current command and the step after it.
  always_comb begin
    ob    = cmd_q.b0;
    done  = 1'b0;
    ph_d  = ph_q;
    idx_d = idx_q;
    esc_d = esc_q;
    db    = (ph_q == P_OPEN) ? cmd_q.open_bytes[8*idx_q[2:0] +: 8]
                             : cmd_q.close_bytes[8*idx_q[2:0] +: 8];
    dlen  = (ph_q == P_OPEN) ? cmd_q.open_len : cmd_q.close_len;
    unique case (cmd_q.kind)
      tdr_pkg::CMD_BYTE: done = 1'b1;
      tdr_pkg::CMD_ERR: begin
        ob   = 8'h00;
        done = 1'b1;
      end
      tdr_pkg::CMD_PAIR: begin
        ob    = (idx_q == 5'd0) ? cmd_q.b0 : cmd_q.b1;
        done  = (idx_q != 5'd0);
        idx_d = idx_q + 5'd1;
      end
      tdr_pkg::CMD_COMMIT: begin
        unique case (ph_q)
          P_HEAD: begin
            ob = tdr_pkg::head_byte(idx_q);
            if (idx_q == 5'(tdr_pkg::HeadLen - 1)) begin
              ph_d  = P_OPEN;
              idx_d = '0;
            end else begin
              idx_d = idx_q + 5'd1;
            end
          end
          P_OPEN, P_CLOSE: begin
            // A quote inside a delimiter is preceded by a backslash.
            if (db == tdr_pkg::CH_QUOTE && !esc_q) begin
              ob    = tdr_pkg::CH_BSLASH;
              esc_d = 1'b1;
            end else begin
              ob    = db;
              esc_d = 1'b0;
              if (idx_q + 5'd1 >= 5'(dlen)) begin
                ph_d  = (ph_q == P_OPEN) ? P_MID : P_TAIL;
                idx_d = '0;
              end else begin
                idx_d = idx_q + 5'd1;
              end
            end
          end
          P_MID: begin
            ob = (idx_q == 5'd1) ? tdr_pkg::CH_SPACE : tdr_pkg::CH_QUOTE;
            if (idx_q == 5'd2) begin
              ph_d  = P_CLOSE;
              idx_d = '0;
            end else begin
              idx_d = idx_q + 5'd1;
            end
          end
          default: begin
            ob    = (idx_q == 5'd0) ? tdr_pkg::CH_QUOTE : tdr_pkg::CH_RBRACE;
            done  = (idx_q == 5'd2);
            idx_d = idx_q + 5'd1;
          end
        endcase
      end
      default: done = 1'b1;
    endcase
  end

  // Command load and output register.
  always_comb begin
    busy_d = busy_q;
    cmd_d  = cmd_q;
    oval_d = oval_q;
    out_d  = out_q;
    if (out_ready_i) oval_d = 1'b0;
    if (pop_o) begin
      busy_d = 1'b1;
      cmd_d  = pop_data_i;
    end else if (busy_q && slot_free) begin
      oval_d             = 1'b1;
      out_d.out_byte     = ob;
      out_d.out_valid    = (cmd_q.kind != tdr_pkg::CMD_ERR);
      out_d.error_code   = (cmd_q.kind == tdr_pkg::CMD_ERR) ? cmd_q.err : tdr_pkg::ERR_NONE;
      out_d.out_last     = cmd_q.last && done;
      if (done) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
      ph_q   <= P_HEAD;
      idx_q  <= '0;
      esc_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      oval_q <= oval_d;
      if (pop_o) begin
        ph_q  <= P_HEAD;
        idx_q <= '0;
        esc_q <= 1'b0;
      end else if (busy_q && slot_free) begin
        ph_q  <= ph_d;
        idx_q <= idx_d;
        esc_q <= esc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/template_delimiter_rewriter.sv
// Channel   Direction  Signals                               Transfer when
// in        input      in_valid_i, in_ready_o, in_data_i     in_valid_i && in_ready_o
// out       output     out_valid_o, out_ready_i, out_data_o  out_valid_o && out_ready_i
// cfg       input      cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i  valid && ready
//
// Each input byte enters the window in F_IDLE; F_RUN then makes each decision the
// lookahead allows (a decision may consume a whole delimiter) and closes the step in F_END.
// The back part loads each command, then sends one output byte per cycle while the output
// is accepted; a set-delimiters tag is 31 to 61 bytes.
// Reset clears the window, the command queue and the output register; no clearing pass.
// A stalled output fills the command queue, which then holds the front part.
`timescale 1ns / 1ps
`default_nettype none

module template_delimiter_rewriter #(
  parameter int unsigned WINDOW_DEPTH = tdr_pkg::DefWindowDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tdr_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tdr_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i
);

  tdr_pkg::cfg_t cfg_q;
  logic          push_valid, fifo_full, fifo_pop, fifo_empty;
  tdr_pkg::cmd_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_bytes  <= 64'd31611;
      cfg_q.open_len    <= 4'd2;
      cfg_q.close_bytes <= 64'd32125;
      cfg_q.close_len   <= 4'd2;
      cfg_q.brace       <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tdr_pkg::CFG_OPEN_BYTES:  cfg_q.open_bytes  <= cfg_data_i;
        tdr_pkg::CFG_OPEN_LEN:    cfg_q.open_len    <= cfg_data_i[3:0];
        tdr_pkg::CFG_CLOSE_BYTES: cfg_q.close_bytes <= cfg_data_i;
        tdr_pkg::CFG_CLOSE_LEN:   cfg_q.close_len   <= cfg_data_i[3:0];
        tdr_pkg::CFG_BRACE:       cfg_q.brace       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tdr_front #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_valid_o(push_valid),
    .push_data_o (push_data),
    .fifo_full_i (fifo_full)
  );

  tdr_cmd_fifo #(
    .DEPTH(tdr_pkg::FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_data_i(push_data),
    .full_o     (fifo_full),
    .pop_i      (fifo_pop),
    .pop_data_o (pop_data),
    .empty_o    (fifo_empty)
  );

  tdr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_o      (fifo_pop),
    .pop_data_i (pop_data),
    .empty_i    (fifo_empty),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
